### rtl/isrt_pkg.sv
// shared types and constants for the interval set range table
// no dependencies; every other file imports this package

package isrt_pkg;

	localparam int MAX_RANGES     = 64;
	localparam int SLOT_BITS      = $clog2(MAX_RANGES);
	localparam int MODULE_ID_BITS = 8;
	localparam int CHUNK_BITS     = 20;

	typedef logic [SLOT_BITS-1:0]      slot_idx_t;
	typedef logic [SLOT_BITS:0]        slot_cnt_t;
	typedef logic [MODULE_ID_BITS-1:0] mod_id_t;
	typedef logic [CHUNK_BITS-1:0]     chunk_t;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_REVERSED = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_WRITE,
		S_RESP
	} state_t;

	// one stored range
	typedef struct packed {
		mod_id_t mod;
		chunk_t  first;
		chunk_t  last;
	} slot_t;

	// answer of the shared compare unit
	typedef struct packed {
		logic   hit;
		chunk_t lo;
		chunk_t hi;
	} cmp_res_t;

endpackage

### rtl/isrt_req_if.sv
// request channel: func, module id and chunk range
// depends on isrt_pkg

interface isrt_req_if
	import isrt_pkg::*;
;
	logic    valid;
	logic    ready;
	logic [1:0] func;
	mod_id_t module_id;
	chunk_t  first_chunk;
	chunk_t  last_chunk;

	modport source (output valid, func, module_id, first_chunk, last_chunk, input ready);
	modport sink   (input valid, func, module_id, first_chunk, last_chunk, output ready);
endinterface

### rtl/isrt_rsp_if.sv
// response channel: lookup hit and status
// depends on isrt_pkg

interface isrt_rsp_if
	import isrt_pkg::*;
;
	logic       valid;
	logic       ready;
	logic       whitelisted;
	logic [1:0] status;

	modport source (output valid, whitelisted, status, input ready);
	modport sink   (input valid, whitelisted, status, output ready);
endinterface

### rtl/isrt_slot_ram.sv
// range store: module id, first and last chunk per slot
// one write port, one registered read port; depends on isrt_pkg

module isrt_slot_ram
	import isrt_pkg::*;
(
	input  logic      clk,
	input  logic      we,
	input  slot_idx_t waddr,
	input  slot_t     wdata,
	input  logic      re,
	input  slot_idx_t raddr,
	output slot_t     rdata
);

	slot_t mem_q [MAX_RANGES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/isrt_cmp.sv
// shared compare unit: module match, overlap/touch or containment, merged bounds
// depends on isrt_pkg

module isrt_cmp
	import isrt_pkg::*;
(
	input  slot_t    entry,
	input  mod_id_t  mod,
	input  chunk_t   lo,
	input  chunk_t   hi,
	input  logic     touch,
	output cmp_res_t res
);

	logic [CHUNK_BITS:0] hi_ext;
	logic [CHUNK_BITS:0] last_ext;
	logic                start_ok;
	logic                end_ok;

	// end plus one kept one bit wider so it never wraps
	assign hi_ext   = {1'b0, hi} + {{CHUNK_BITS{1'b0}}, touch};
	assign last_ext = {1'b0, entry.last} + {{CHUNK_BITS{1'b0}}, touch};
	assign start_ok = {1'b0, entry.first} <= hi_ext;
	assign end_ok   = {1'b0, lo} <= last_ext;

	assign res.hit = (entry.mod == mod) && start_ok && end_ok;
	assign res.lo  = (entry.first < lo) ? entry.first : lo;
	assign res.hi  = (entry.last > hi) ? entry.last : hi;

endmodule

### rtl/interval_set_range_table.sv
// interval set range table: add/merge, lookup and clear over MAX_RANGES slots
// lookup and add walk all MAX_RANGES slots before the result beat, and add then writes the merged range;
// clear, reversed range and unused func answer without a walk; one request at a time
// throughput set by the slot walk: one slot read from the range store per cycle
// reset clears all valid bits at once; the range store itself is not cleared
// depends on isrt_pkg, isrt_req_if, isrt_rsp_if, isrt_slot_ram, isrt_cmp

module interval_set_range_table
	import isrt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	isrt_req_if.sink   req,
	isrt_rsp_if.source rsp
);

	state_t state_q, state_d;

	// control
	logic [MAX_RANGES-1:0] valid_q;
	slot_cnt_t             rd_cnt_q;
	logic                  cmp_vld_s1;
	logic                  free_found_q;
	logic                  rsp_vld_q;

	// payload
	func_t     op_q;
	mod_id_t   mod_q;
	chunk_t    lo_q;
	chunk_t    hi_q;
	logic      hit_q;
	status_t   status_q;
	slot_idx_t cmp_idx_s1;
	slot_idx_t free_idx_q;
	logic      rsp_hit_q;
	status_t   rsp_status_q;

	// sequencer outputs
	logic accept;
	logic rd_issue;
	logic walk_done;
	logic ram_we;
	logic rsp_load;

	slot_t     rd_entry;
	slot_t     wr_entry;
	cmp_res_t  cmp_res;
	logic      slot_live;
	logic      absorb;
	logic      is_add;

	// range store, read one slot per cycle during the walk
	isrt_slot_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx_q),
		.wdata (wr_entry),
		.re    (rd_issue),
		.raddr (rd_cnt_q[SLOT_BITS-1:0]),
		.rdata (rd_entry)
	);

	assign wr_entry = '{mod: mod_q, first: lo_q, last: hi_q};
	assign is_add   = (op_q == FUNC_ADD);

	// add tests overlap or touch against the growing merged range,
	// lookup tests containment of the chunk held in both lo and hi
	isrt_cmp u_cmp (
		.entry (rd_entry),
		.mod   (mod_q),
		.lo    (lo_q),
		.hi    (hi_q),
		.touch (is_add),
		.res   (cmp_res)
	);

	assign slot_live = valid_q[cmp_idx_s1];
	assign absorb    = cmp_vld_s1 && slot_live && cmp_res.hit;
	assign walk_done = (rd_cnt_q == slot_cnt_t'(MAX_RANGES)) && !cmp_vld_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.func)
						FUNC_ADD: begin
							state_d = (req.last_chunk < req.first_chunk) ? S_RESP : S_WALK;
						end
						FUNC_LOOKUP: state_d = S_WALK;
						default:     state_d = S_RESP;
					endcase
				end
			end
			S_WALK: begin
				if (walk_done) begin
					state_d = is_add ? S_WRITE : S_RESP;
				end
			end
			S_WRITE: state_d = S_RESP;
			S_RESP: begin
				if (!rsp_vld_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		rd_issue  = 1'b0;
		ram_we    = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			S_IDLE:  req.ready = 1'b1;
			S_WALK:  rd_issue  = (rd_cnt_q < slot_cnt_t'(MAX_RANGES));
			S_WRITE: ram_we    = free_found_q;
			S_RESP:  rsp_load  = !rsp_vld_q || rsp.ready;
			default: req.ready = 1'b0;
		endcase
	end

	assign accept = req.valid && req.ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			rsp_vld_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= rd_issue;

			if (accept) begin
				rd_cnt_q     <= '0;
				free_found_q <= 1'b0;
				if (req.func == FUNC_CLEAR) begin
					valid_q <= '0;
				end
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + slot_cnt_t'(1);
			end

			// absorbed slots are freed as the walk passes them; the first slot
			// that is free or freed takes the merged range
			if (state_q == S_WALK && is_add) begin
				if (absorb) begin
					valid_q[cmp_idx_s1] <= 1'b0;
				end
				if (cmp_vld_s1 && !free_found_q && (!slot_live || absorb)) begin
					free_found_q <= 1'b1;
				end
			end

			if (ram_we) begin
				valid_q[free_idx_q] <= 1'b1;
			end

			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_cnt_q[SLOT_BITS-1:0];

		if (accept) begin
			op_q     <= func_t'(req.func);
			mod_q    <= req.module_id;
			lo_q     <= req.first_chunk;
			hi_q     <= (req.func == FUNC_ADD) ? req.last_chunk : req.first_chunk;
			hit_q    <= 1'b0;
			status_q <= ((req.func == FUNC_ADD) && (req.last_chunk < req.first_chunk))
				? ST_REVERSED : ST_DONE;
		end

		if (state_q == S_WALK) begin
			if (is_add) begin
				if (absorb) begin
					lo_q <= cmp_res.lo;
					hi_q <= cmp_res.hi;
				end
				if (cmp_vld_s1 && !free_found_q && (!slot_live || absorb)) begin
					free_idx_q <= cmp_idx_s1;
				end
			end else if (absorb) begin
				hit_q <= 1'b1;
			end
		end

		// no free or freed slot: table full, nothing changes
		if (state_q == S_WRITE && !free_found_q) begin
			status_q <= ST_FULL;
		end

		if (rsp_load) begin
			rsp_hit_q    <= hit_q && (op_q == FUNC_LOOKUP);
			rsp_status_q <= status_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.whitelisted = rsp_hit_q;
	assign rsp.status      = rsp_status_q;

endmodule

### test/testbench.sv
// self-checking testbench for interval_set_range_table: directed rows, then random bursts
// depends on isrt_pkg, isrt_req_if, isrt_rsp_if and the block itself
`timescale 1ns / 1ps

module testbench;
	import isrt_pkg::*;

	// func code the block does not define; it must answer as a no-op
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CHUNK_TOP = (1 << CHUNK_BITS) - 1;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT = 1000000;
	// add and lookup walk every slot, plus the overhead of the other states
	localparam int TAIL_CYCLES = MAX_RANGES + 8;

	// one response beat as the block should send it
	typedef struct packed {
		logic    whitelisted;
		status_t status;
	} answer_t;

	// one row of the directed part; fixed rows carry an answer typed in by hand
	typedef struct packed {
		logic [1:0] func;
		mod_id_t    mod;
		chunk_t     first;
		chunk_t     last;
		bit         fixed;
		answer_t    answer;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;

	isrt_req_if req ();
	isrt_rsp_if rsp ();

	interval_set_range_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// predicted contents of the range store
	bit      held_valid [MAX_RANGES];
	mod_id_t held_mod   [MAX_RANGES];
	chunk_t  held_first [MAX_RANGES];
	chunk_t  held_last  [MAX_RANGES];

	answer_t pending_answers [$];
	int      items_sent = 0;
	int      mismatches = 0;
	int      cycle_count = 0;
	// no idling on either side while set
	bit      steady = 1'b0;

	// directed rows: extremes, touching without wrap, reversed ranges, clear, unused func
	directed_row_t directed_rows [25] = '{
		// empty store after reset
		'{FUNC_LOOKUP, 8'h00, 20'h00000, 20'h00000, 1'b1, '{1'b0, ST_DONE}},
		'{FUNC_ADD,    8'h00, 20'h00000, 20'h00000, 1'b1, '{1'b0, ST_DONE}},
		'{FUNC_ADD,    8'hff, 20'hfffff, 20'hfffff, 1'b1, '{1'b0, ST_DONE}},
		// top chunk must not merge with chunk zero: end plus one does not wrap
		'{FUNC_ADD,    8'h00, 20'hfffff, 20'hfffff, 1'b1, '{1'b0, ST_DONE}},
		'{FUNC_LOOKUP, 8'h00, 20'hfffff, 20'h00000, 1'b1, '{1'b1, ST_DONE}},
		'{FUNC_LOOKUP, 8'hff, 20'h00000, 20'hfffff, 1'b1, '{1'b0, ST_DONE}},
		// reversed ranges are dropped
		'{FUNC_ADD,    8'h00, 20'h00005, 20'h00003, 1'b1, '{1'b0, ST_REVERSED}},
		'{FUNC_ADD,    8'h00, 20'hfffff, 20'h00000, 1'b1, '{1'b0, ST_REVERSED}},
		// touching, gap, then a bridge across two ranges
		'{FUNC_ADD,    8'h00, 20'h00001, 20'h00001, 1'b0, '0},
		'{FUNC_LOOKUP, 8'h00, 20'h00001, 20'h00000, 1'b0, '0},
		'{FUNC_ADD,    8'h00, 20'h00003, 20'h00004, 1'b0, '0},
		'{FUNC_LOOKUP, 8'h00, 20'h00002, 20'h00000, 1'b0, '0},
		'{FUNC_ADD,    8'h00, 20'h00002, 20'h00002, 1'b0, '0},
		'{FUNC_LOOKUP, 8'h00, 20'h00002, 20'h00000, 1'b0, '0},
		// one wide add swallows every range of the module, top chunk by touch
		'{FUNC_ADD,    8'h00, 20'h00000, 20'hffffe, 1'b0, '0},
		'{FUNC_LOOKUP, 8'h00, 20'h80000, 20'h00000, 1'b0, '0},
		'{FUNC_LOOKUP, 8'hff, 20'hffffe, 20'h00000, 1'b0, '0},
		// stops one short of touching the other module's top range
		'{FUNC_ADD,    8'hff, 20'h00000, 20'hffffd, 1'b0, '0},
		'{FUNC_LOOKUP, 8'hff, 20'hffffe, 20'h00000, 1'b0, '0},
		'{FUNC_UNUSED, 8'hff, 20'hfffff, 20'hfffff, 1'b1, '{1'b0, ST_DONE}},
		'{FUNC_CLEAR,  8'hff, 20'hfffff, 20'hfffff, 1'b1, '{1'b0, ST_DONE}},
		'{FUNC_LOOKUP, 8'h00, 20'h00000, 20'h00000, 1'b1, '{1'b0, ST_DONE}},
		'{FUNC_LOOKUP, 8'hff, 20'hfffff, 20'h00000, 1'b1, '{1'b0, ST_DONE}},
		'{FUNC_ADD,    8'haa, 20'h55555, 20'haaaaa, 1'b0, '0},
		'{FUNC_LOOKUP, 8'haa, 20'haaaaa, 20'h55555, 1'b0, '0}
	};

	// add: absorb every range of the module that overlaps or touches, then store the union
	function automatic status_t merge_range(mod_id_t m, chunk_t lo, chunk_t hi);
		logic [CHUNK_BITS:0] span_lo;
		logic [CHUNK_BITS:0] span_hi;
		bit                  absorb [MAX_RANGES];
		int                  free_at;
		if (hi < lo)
			return ST_REVERSED;
		span_lo = {1'b0, lo};
		span_hi = {1'b0, hi};
		free_at = -1;
		// the span grows as the walk goes, so later slots see the widened range
		for (int i = 0; i < MAX_RANGES; i++) begin
			absorb[i] = 1'b0;
			if (held_valid[i] && held_mod[i] == m &&
			    {1'b0, held_first[i]} <= span_hi + 1 &&
			    span_lo <= {1'b0, held_last[i]} + 1) begin
				absorb[i] = 1'b1;
				if (held_first[i] < span_lo)
					span_lo = {1'b0, held_first[i]};
				if (held_last[i] > span_hi)
					span_hi = {1'b0, held_last[i]};
			end
		end
		// lowest slot that is empty or about to be freed
		for (int i = 0; i < MAX_RANGES; i++) begin
			if (free_at < 0 && (!held_valid[i] || absorb[i]))
				free_at = i;
		end
		if (free_at < 0)
			return ST_FULL;
		for (int i = 0; i < MAX_RANGES; i++) begin
			if (absorb[i])
				held_valid[i] = 1'b0;
		end
		held_valid[free_at] = 1'b1;
		held_mod[free_at]   = m;
		held_first[free_at] = span_lo[CHUNK_BITS-1:0];
		held_last[free_at]  = span_hi[CHUNK_BITS-1:0];
		return ST_DONE;
	endfunction

	function automatic logic chunk_listed(mod_id_t m, chunk_t c);
		for (int i = 0; i < MAX_RANGES; i++) begin
			if (held_valid[i] && held_mod[i] == m && c >= held_first[i] && c <= held_last[i])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// updates the predicted store and returns the beat the block should send
	function automatic answer_t predict_answer(logic [1:0] f, mod_id_t m, chunk_t lo, chunk_t hi);
		answer_t a;
		a = '{1'b0, ST_DONE};
		if (f == FUNC_ADD) begin
			a.status = merge_range(m, lo, hi);
		end else if (f == FUNC_LOOKUP) begin
			a.whitelisted = chunk_listed(m, lo);
		end else if (f == FUNC_CLEAR) begin
			for (int i = 0; i < MAX_RANGES; i++)
				held_valid[i] = 1'b0;
		end
		return a;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken;
	// valid stays high on return so back-to-back requests need no second assignment
	task automatic offer_request(input logic [1:0] f, input mod_id_t m, input chunk_t lo,
			input chunk_t hi, input bit fixed = 1'b0, input answer_t fixed_answer = '0);
		answer_t a;
		while (!steady && $urandom_range(99) < 37) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid       <= 1'b1;
		req.func        <= f;
		req.module_id   <= m;
		req.first_chunk <= lo;
		req.last_chunk  <= hi;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		// beat accepted at this edge
		a = predict_answer(f, m, lo, hi);
		if (fixed)
			a = fixed_answer;
		pending_answers = {pending_answers, a};
		items_sent++;
		steady = items_sent >= 400 && items_sent < 650;
		@(negedge clk);
	endtask

	// sender holds off until every outstanding answer has come back
	task automatic wait_for_answers();
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_answers.size() != 0);
	endtask

	// mostly well-formed traffic: a few modules working in a 256-chunk window
	task automatic merge_burst();
		int      base;
		int      lo;
		int      hi;
		int      swap;
		int      pick;
		mod_id_t mods [4];
		mod_id_t m;
		case ($urandom_range(3))
			0: base = 0;
			1: base = CHUNK_TOP - 255;
			default: base = $urandom_range(CHUNK_TOP - 255);
		endcase
		foreach (mods[k])
			mods[k] = mod_id_t'($urandom_range(255));
		if ($urandom_range(1))
			offer_request(FUNC_CLEAR, mod_id_t'($urandom_range(255)),
				chunk_t'($urandom_range(CHUNK_TOP)), chunk_t'($urandom_range(CHUNK_TOP)));
		repeat ($urandom_range(20, 60)) begin
			pick = $urandom_range(99);
			m    = mods[$urandom_range(3)];
			lo   = base + $urandom_range(240);
			hi   = lo + $urandom_range(15);
			if (pick < 50) begin
				// the odd reversed range among the adds
				if ($urandom_range(19) == 0) begin
					swap = lo;
					lo   = hi;
					hi   = swap;
				end
				offer_request(FUNC_ADD, m, chunk_t'(lo), chunk_t'(hi));
			end else if (pick < 93) begin
				offer_request(FUNC_LOOKUP, m, chunk_t'(base + $urandom_range(255)),
					chunk_t'($urandom_range(CHUNK_TOP)));
			end else if (pick < 95) begin
				offer_request(FUNC_CLEAR, m, chunk_t'(lo), chunk_t'(hi));
			end else if (pick < 97) begin
				offer_request(FUNC_UNUSED, m, chunk_t'(lo), chunk_t'(hi));
			end else begin
				offer_request(2'($urandom_range(3)), mod_id_t'($urandom_range(255)),
					chunk_t'($urandom_range(CHUNK_TOP)), chunk_t'($urandom_range(CHUNK_TOP)));
			end
		end
	endtask

	// fills every slot with disjoint ranges, overflows, then frees slots by merging
	task automatic fill_to_capacity();
		int      base;
		int      k;
		int      pair_at;
		mod_id_t mod_a;
		mod_id_t mod_b;
		mod_id_t fill_mod [MAX_RANGES + 3];
		wait_for_answers();
		offer_request(FUNC_CLEAR, 8'h00, 20'h00000, 20'h00000);
		base  = $urandom_range(CHUNK_TOP - 4 * (MAX_RANGES + 8));
		mod_a = mod_id_t'($urandom_range(255));
		mod_b = mod_id_t'($urandom_range(255));
		// two-chunk ranges four apart never touch; the last three find no slot
		for (k = 0; k < MAX_RANGES + 3; k++) begin
			fill_mod[k] = $urandom_range(1) ? mod_a : mod_b;
			offer_request(FUNC_ADD, fill_mod[k], chunk_t'(base + 4 * k),
				chunk_t'(base + 4 * k + 1));
		end
		repeat (4) begin
			k = $urandom_range(MAX_RANGES + 2);
			offer_request(FUNC_LOOKUP, fill_mod[k], chunk_t'(base + 4 * k + $urandom_range(3)),
				chunk_t'($urandom_range(CHUNK_TOP)));
		end
		offer_request(FUNC_ADD, fill_mod[0], chunk_t'(base + 1), chunk_t'(base));
		// growing a stored range by touch still works with the store full
		k = $urandom_range(MAX_RANGES - 2);
		offer_request(FUNC_ADD, fill_mod[k], chunk_t'(base + 4 * k + 2),
			chunk_t'(base + 4 * k + 2));
		// bridge two neighbours of one module, which frees a slot
		pair_at = -1;
		for (k = 0; k < MAX_RANGES - 1; k++) begin
			if (pair_at < 0 && fill_mod[k] == fill_mod[k + 1])
				pair_at = k;
		end
		if (pair_at >= 0)
			offer_request(FUNC_ADD, fill_mod[pair_at], chunk_t'(base + 4 * pair_at + 2),
				chunk_t'(base + 4 * pair_at + 3));
		offer_request(FUNC_ADD, mod_a, chunk_t'(base + 4 * (MAX_RANGES + 5)),
			chunk_t'(base + 4 * (MAX_RANGES + 5)));
		offer_request(FUNC_ADD, mod_b, chunk_t'(base + 4 * (MAX_RANGES + 7)),
			chunk_t'(base + 4 * (MAX_RANGES + 7)));
		offer_request(FUNC_LOOKUP, mod_a, chunk_t'(base + 4 * (MAX_RANGES + 5)), 20'h00000);
	endtask

	// anything the fields allow, unused func included
	task automatic noise_burst();
		repeat ($urandom_range(8, 20))
			offer_request(2'($urandom_range(3)), mod_id_t'($urandom_range(255)),
				chunk_t'($urandom_range(CHUNK_TOP)), chunk_t'($urandom_range(CHUNK_TOP)));
	endtask

	// receiver stalls at random outside the steady stretch
	always @(negedge clk)
		rsp.ready <= steady || $urandom_range(99) >= 37;

	// compare each response beat with the oldest prediction
	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: response beat with nothing outstanding, whitelisted %b status %0d",
					$time, rsp.whitelisted, rsp.status);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp.whitelisted !== want.whitelisted) begin
					$display("%0t: whitelisted expected %b got %b", $time, want.whitelisted,
						rsp.whitelisted);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
					mismatches++;
				end
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d answers outstanding", $time,
				pending_answers.size());
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		int pick;
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.func        = FUNC_ADD;
		req.module_id   = '0;
		req.first_chunk = '0;
		req.last_chunk  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			offer_request(directed_rows[r].func, directed_rows[r].mod, directed_rows[r].first,
				directed_rows[r].last, directed_rows[r].fixed, directed_rows[r].answer);

		// random part opens with a full store so overflow is always reached
		fill_to_capacity();
		while (items_sent < $size(directed_rows) + RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 10)
				fill_to_capacity();
			else if (pick < 20)
				noise_burst();
			else
				merge_burst();
		end

		wait_for_answers();
		// let any stray beat show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
